// ----- design/rsld_pkg.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rsld_pkg
// Shared types, constants and step tables of the rotation sensor level
// decoder.
// ----------------------------------------------------------------------------
package rsld_pkg;

   localparam int NumChannels = 3;
   localparam int ChanW       = 2;
   localparam int RawW        = 16;
   localparam int CountW      = 32;
   localparam int PhaseW      = 2;
   localparam int NumLevels   = 4;
   localparam int CsrIdxW     = 3;
   localparam int QueueDepth  = 2;
   localparam int QueuePtrW   = (QueueDepth > 1) ? $clog2(QueueDepth) : 1;
   localparam int QueueCntW   = $clog2(QueueDepth + 1);

   localparam logic [RawW-1:0] LevelZeroReset  = 16'(1023 << 6);
   localparam logic [RawW-1:0] LevelOneReset   = 16'(833 << 6);
   localparam logic [RawW-1:0] LevelTwoReset   = 16'(405 << 6);
   localparam logic [RawW-1:0] LevelThreeReset = 16'(623 << 6);
   localparam logic [RawW-1:0] WindowReset     = 16'(40 << 6);

   typedef enum logic [CsrIdxW-1:0] {
      REG_LEVEL_ZERO   = 3'd0,
      REG_LEVEL_ONE    = 3'd1,
      REG_LEVEL_TWO    = 3'd2,
      REG_LEVEL_THREE  = 3'd3,
      REG_WINDOW_WIDTH = 3'd4
   } csr_index_type;

   typedef logic [PhaseW-1:0] phase_type;

   // classified word passed from front to back
   typedef struct packed {
      logic                   command;
      logic [ChanW-1:0]       channel;
      logic [NumLevels-1:0]   match;
      phase_type              seed;
      logic [CountW-1:0]      position;
   } word_type;

   typedef struct packed {
      logic [ChanW-1:0]  out_channel;
      logic [CountW-1:0] count;
      phase_type         phase;
   } result_type;

   localparam logic CmdSample = 1'b0;
   localparam logic CmdSet    = 1'b1;

   function automatic phase_type first_nb(input phase_type p);
      phase_type r;
      case (p)
         2'd0:    r = 2'd3;
         2'd1:    r = 2'd0;
         2'd2:    r = 2'd3;
         default: r = 2'd0;
      endcase
      return r;
   endfunction

   function automatic phase_type second_nb(input phase_type p);
      phase_type r;
      case (p)
         2'd0:    r = 2'd1;
         2'd1:    r = 2'd2;
         2'd2:    r = 2'd1;
         default: r = 2'd2;
      endcase
      return r;
   endfunction

   // first neighbour steps up from phases 2 and 3
   function automatic logic first_up(input phase_type p);
      return p[1];
   endfunction

endpackage
`default_nettype wire

// ----- design/rsld_if.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rsld interfaces
// Valid/ready channels for sample words, result words and register writes.
// ----------------------------------------------------------------------------
interface rsld_req_if;
   logic                           valid;
   logic                           ready;
   logic                           command;
   logic [rsld_pkg::ChanW-1:0]     channel;
   logic [rsld_pkg::RawW-1:0]      raw_value;
   logic signed [rsld_pkg::CountW-1:0] position;

   modport source (output valid, command, channel, raw_value, position, input ready);
   modport sink   (input valid, command, channel, raw_value, position, output ready);
endinterface

interface rsld_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [rsld_pkg::ChanW-1:0]         out_channel;
   logic signed [rsld_pkg::CountW-1:0] count;
   logic [rsld_pkg::PhaseW-1:0]        phase;

   modport source (output valid, out_channel, count, phase, input ready);
   modport sink   (input valid, out_channel, count, phase, output ready);
endinterface

interface rsld_csr_if;
   logic                         valid;
   logic                         ready;
   logic [rsld_pkg::CsrIdxW-1:0] index;
   logic [rsld_pkg::RawW-1:0]    data;

   modport source (output valid, index, data, input ready);
   modport sink   (input valid, index, data, output ready);
endinterface
`default_nettype wire

// ----- design/rsld_front.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rsld_front
// Holds the level registers, accepts words and classifies each sample
// against all four level windows and the seed thresholds.
// ----------------------------------------------------------------------------
module rsld_front (
   input  wire logic               clock,
   input  wire logic               reset,
   rsld_req_if.sink                req_port,
   rsld_csr_if.sink                csr_port,
   input  wire logic               q_full,
   output      logic               q_push,
   output      rsld_pkg::word_type q_word
);

   logic [rsld_pkg::RawW-1:0] level_ff [rsld_pkg::NumLevels];
   logic [rsld_pkg::RawW-1:0] level_in [rsld_pkg::NumLevels];
   logic [rsld_pkg::RawW-1:0] window_ff;
   logic [rsld_pkg::RawW-1:0] window_in;

   // strict window compare, no wraparound
   function automatic logic in_window(input logic [rsld_pkg::RawW-1:0] raw,
                                      input logic [rsld_pkg::RawW-1:0] lv,
                                      input logic [rsld_pkg::RawW-1:0] w);
      logic [rsld_pkg::RawW:0] raw_w;
      logic [rsld_pkg::RawW:0] lv_w;
      raw_w = {1'b0, raw} + {1'b0, w};
      lv_w  = {1'b0, lv} + {1'b0, w};
      return ({1'b0, lv} < raw_w) && ({1'b0, raw} < lv_w);
   endfunction

   assign csr_port.ready = 1'b1;
   assign req_port.ready = !q_full;
   assign q_push         = req_port.valid && !q_full;

   always_comb begin
      level_in  = level_ff;
      window_in = window_ff;
      if (csr_port.valid) begin
         case (csr_port.index)
            rsld_pkg::REG_LEVEL_ZERO:   level_in[0] = csr_port.data;
            rsld_pkg::REG_LEVEL_ONE:    level_in[1] = csr_port.data;
            rsld_pkg::REG_LEVEL_TWO:    level_in[2] = csr_port.data;
            rsld_pkg::REG_LEVEL_THREE:  level_in[3] = csr_port.data;
            rsld_pkg::REG_WINDOW_WIDTH: window_in   = csr_port.data;
            default: ;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         level_ff[0] <= rsld_pkg::LevelZeroReset;
         level_ff[1] <= rsld_pkg::LevelOneReset;
         level_ff[2] <= rsld_pkg::LevelTwoReset;
         level_ff[3] <= rsld_pkg::LevelThreeReset;
         window_ff   <= rsld_pkg::WindowReset;
      end else begin
         level_ff  <= level_in;
         window_ff <= window_in;
      end
   end

   always_comb begin
      q_word.command  = req_port.command;
      q_word.channel  = req_port.channel;
      q_word.position = req_port.position;
      for (int i = 0; i < rsld_pkg::NumLevels; i++) begin
         q_word.match[i] = in_window(req_port.raw_value, level_ff[i], window_ff);
      end
      if (req_port.raw_value <= level_ff[2]) begin
         q_word.seed = 2'd2;
      end else if (req_port.raw_value <= level_ff[3]) begin
         q_word.seed = 2'd3;
      end else if (req_port.raw_value <= level_ff[1]) begin
         q_word.seed = 2'd1;
      end else begin
         q_word.seed = 2'd0;
      end
   end

endmodule
`default_nettype wire

// ----- design/rsld_queue.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rsld_queue
// Short register queue of classified words between front and back.
// ----------------------------------------------------------------------------
module rsld_queue (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               push,
   input  wire rsld_pkg::word_type push_word,
   input  wire logic               pop,
   output      logic               full,
   output      logic               not_empty,
   output      rsld_pkg::word_type head_word
);

   rsld_pkg::word_type               entry_ff [rsld_pkg::QueueDepth];
   logic [rsld_pkg::QueuePtrW-1:0]   wr_ptr_ff;
   logic [rsld_pkg::QueuePtrW-1:0]   wr_ptr_in;
   logic [rsld_pkg::QueuePtrW-1:0]   rd_ptr_ff;
   logic [rsld_pkg::QueuePtrW-1:0]   rd_ptr_in;
   logic [rsld_pkg::QueueCntW-1:0]   count_ff;
   logic [rsld_pkg::QueueCntW-1:0]   count_in;

   function automatic logic [rsld_pkg::QueuePtrW-1:0] next_ptr(
      input logic [rsld_pkg::QueuePtrW-1:0] p);
      logic [rsld_pkg::QueuePtrW-1:0] r;
      if (p == rsld_pkg::QueuePtrW'(rsld_pkg::QueueDepth - 1)) begin
         r = '0;
      end else begin
         r = p + 1'b1;
      end
      return r;
   endfunction

   assign full      = (count_ff == rsld_pkg::QueueCntW'(rsld_pkg::QueueDepth));
   assign not_empty = (count_ff != '0);
   assign head_word = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? next_ptr(wr_ptr_ff) : wr_ptr_ff;
      rd_ptr_in = pop ? next_ptr(rd_ptr_ff) : rd_ptr_ff;
      count_in  = count_ff;
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entry_ff[wr_ptr_ff] <= push_word;
      end
   end

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= rsld_pkg::QueueCntW'(rsld_pkg::QueueDepth))
      else $error("queue count above depth");

   a_push_fills: assert property (@(posedge clock) disable iff (reset)
      (push && !pop) |=> not_empty)
      else $error("queue empty after push");
`endif

endmodule
`default_nettype wire

// ----- design/rsld_back.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rsld_back
// Per-channel phase and count stores; applies each classified word and
// holds the result word in an output register.
// ----------------------------------------------------------------------------
module rsld_back (
   input  wire logic               clock,
   input  wire logic               reset,
   input  wire logic               q_valid,
   input  wire rsld_pkg::word_type q_word,
   output      logic               q_pop,
   rsld_rsp_if.source              rsp_port
);

   rsld_pkg::phase_type         phase_ff [rsld_pkg::NumChannels];
   logic [rsld_pkg::CountW-1:0] count_ff [rsld_pkg::NumChannels];
   logic                        out_valid_ff;
   logic                        out_valid_in;
   rsld_pkg::result_type        out_ff;
   rsld_pkg::result_type        out_in;

   logic                        chan_ok;
   rsld_pkg::phase_type         cur_phase;
   logic [rsld_pkg::CountW-1:0] cur_count;
   rsld_pkg::phase_type         new_phase;
   logic [rsld_pkg::CountW-1:0] new_count;
   rsld_pkg::phase_type         nb_a;
   rsld_pkg::phase_type         nb_b;

   assign q_pop = q_valid && (!out_valid_ff || rsp_port.ready);

   always_comb begin
      chan_ok   = 1'b0;
      cur_phase = '0;
      cur_count = '0;
      for (int i = 0; i < rsld_pkg::NumChannels; i++) begin
         if (int'(q_word.channel) == i) begin
            chan_ok   = 1'b1;
            cur_phase = phase_ff[i];
            cur_count = count_ff[i];
         end
      end
      nb_a      = rsld_pkg::first_nb(cur_phase);
      nb_b      = rsld_pkg::second_nb(cur_phase);
      new_phase = cur_phase;
      new_count = cur_count;
      if (q_word.command == rsld_pkg::CmdSet) begin
         new_phase = q_word.seed;
         new_count = q_word.position;
      end else if (q_word.match[nb_a]) begin
         new_phase = nb_a;
         new_count = rsld_pkg::first_up(cur_phase) ? cur_count + 1'b1 : cur_count - 1'b1;
      end else if (q_word.match[nb_b]) begin
         new_phase = nb_b;
         new_count = rsld_pkg::first_up(cur_phase) ? cur_count - 1'b1 : cur_count + 1'b1;
      end
      if (!chan_ok) begin
         new_phase = '0;
         new_count = '0;
      end
   end

   always_comb begin
      out_valid_in = out_valid_ff;
      out_in       = out_ff;
      if (q_pop) begin
         out_valid_in       = 1'b1;
         out_in.out_channel = q_word.channel;
         out_in.count       = new_count;
         out_in.phase       = new_phase;
      end else if (rsp_port.ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
         for (int i = 0; i < rsld_pkg::NumChannels; i++) begin
            phase_ff[i] <= '0;
            count_ff[i] <= '0;
         end
      end else begin
         out_valid_ff <= out_valid_in;
         for (int i = 0; i < rsld_pkg::NumChannels; i++) begin
            if (q_pop && int'(q_word.channel) == i) begin
               phase_ff[i] <= new_phase;
               count_ff[i] <= new_count;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   assign rsp_port.valid       = out_valid_ff;
   assign rsp_port.out_channel = out_ff.out_channel;
   assign rsp_port.count       = out_ff.count;
   assign rsp_port.phase       = out_ff.phase;

`ifndef SYNTHESIS
   a_bad_channel_zero: assert property (@(posedge clock) disable iff (reset)
      (q_pop && !chan_ok) |=> (out_valid_ff && out_ff.count == '0 && out_ff.phase == '0))
      else $error("out of range channel gave nonzero result");

   a_set_loads: assert property (@(posedge clock) disable iff (reset)
      (q_pop && chan_ok && q_word.command == rsld_pkg::CmdSet)
      |=> (out_ff.count == $past(q_word.position) && out_ff.phase == $past(q_word.seed)))
      else $error("set word did not load position");

   a_pop_valid: assert property (@(posedge clock) disable iff (reset)
      q_pop |=> out_valid_ff)
      else $error("popped word not presented");
`endif

endmodule
`default_nettype wire

// ----- design/rotation_sensor_level_decoder.sv -----
`default_nettype none
// ----------------------------------------------------------------------------
// rotation_sensor_level_decoder
// Four-level analog rotation decoder with one count per sensor channel.
//
// req_port carries words of command, channel, raw_value and position; a
// sample word steps the channel's count when the value falls inside the
// window of a neighbouring level, a set word loads the count and seeds the
// phase. Every accepted word yields one rsp_port word with the channel,
// its count and phase; an out of range channel returns zero count and
// phase and changes nothing. csr_port writes the four levels and the window
// half-width (always ready); write only while no word is in flight. Accepted
// words are queued; the back registers each result. Throughput is one word
// per cycle while rsp_port is ready: the front classifies in the accept
// cycle, a two-word queue feeds the per-channel read-modify-write. When
// rsp_port stalls, the output register holds, the queue fills and
// req_port.ready drops once it is full. Synchronous reset clears all counts
// and phases to zero, loads the level defaults and empties the queue.
// ----------------------------------------------------------------------------
module rotation_sensor_level_decoder (
   input  wire logic clock,
   input  wire logic reset,
   rsld_req_if.sink  req_port,
   rsld_rsp_if.source rsp_port,
   rsld_csr_if.sink  csr_port
);

   logic               q_full;
   logic               q_push;
   logic               q_pop;
   logic               q_not_empty;
   rsld_pkg::word_type q_push_word;
   rsld_pkg::word_type q_head_word;

   rsld_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_port),
      .csr_port (csr_port),
      .q_full   (q_full),
      .q_push   (q_push),
      .q_word   (q_push_word)
   );

   rsld_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_word (q_push_word),
      .pop       (q_pop),
      .full      (q_full),
      .not_empty (q_not_empty),
      .head_word (q_head_word)
   );

   rsld_back u_back (
      .clock    (clock),
      .reset    (reset),
      .q_valid  (q_not_empty),
      .q_word   (q_head_word),
      .q_pop    (q_pop),
      .rsp_port (rsp_port)
   );

endmodule
`default_nettype wire

// ----- tb/sv/tb.sv -----
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the rotation sensor level decoder. Sample and set
// words go in over req_port while a cycle-free decoder model tracks each
// channel's phase and count and queues the word the block should return.
// Every rsp_port word is compared field by field with the oldest queued word.
// Register writes on csr_port happen only with the block drained. Traffic
// runs a directed pass, corner register settings, then random phases with
// sender gaps and receiver stalls.
// ----------------------------------------------------------------------------
module tb;

   localparam int QuietLimit = 5000;

   logic clock;
   logic reset;

   rsld_req_if req_bus ();
   rsld_rsp_if rsp_bus ();
   rsld_csr_if csr_bus ();

   rotation_sensor_level_decoder dut (
      .clock   (clock),
      .reset   (reset),
      .req_port(req_bus),
      .rsp_port(rsp_bus),
      .csr_port(csr_bus)
   );

   // decoder model state
   rsld_pkg::phase_type         phase_model [rsld_pkg::NumChannels];
   logic [rsld_pkg::CountW-1:0] count_model [rsld_pkg::NumChannels];
   logic [rsld_pkg::RawW-1:0]   level_reg [rsld_pkg::NumLevels];
   logic [rsld_pkg::RawW-1:0]   window_reg;

   rsld_pkg::result_type expected_words [$];
   int                   src_idle_pct;
   int                   snk_stall_pct;
   int                   fail_count;

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   function automatic bit near_level(input logic [rsld_pkg::RawW-1:0] raw,
                                     input rsld_pkg::phase_type k);
      int unsigned lv;
      int unsigned rv;
      int unsigned w;
      lv = level_reg[k];
      rv = raw;
      w  = window_reg;
      return (lv < rv + w) && (rv < lv + w);
   endfunction

   function automatic rsld_pkg::result_type decode_word(
      input logic                        cmd,
      input logic [rsld_pkg::ChanW-1:0]  ch,
      input logic [rsld_pkg::RawW-1:0]   raw,
      input logic [rsld_pkg::CountW-1:0] pos);
      rsld_pkg::result_type r;
      rsld_pkg::phase_type  p;
      rsld_pkg::phase_type  nb_a;
      rsld_pkg::phase_type  nb_b;
      logic                 a_up;
      r.out_channel = ch;
      r.count       = '0;
      r.phase       = '0;
      if (ch >= rsld_pkg::NumChannels) return r;
      p = phase_model[ch];
      if (cmd == rsld_pkg::CmdSet) begin
         if (raw <= level_reg[2]) p = 2'd2;
         else if (raw <= level_reg[3]) p = 2'd3;
         else if (raw <= level_reg[1]) p = 2'd1;
         else p = 2'd0;
         count_model[ch] = pos;
      end else begin
         // even phases look at 3 then 1, odd phases at 0 then 2
         nb_a = p[0] ? 2'd0 : 2'd3;
         nb_b = p[0] ? 2'd2 : 2'd1;
         a_up = p[1];
         if (near_level(raw, nb_a)) begin
            count_model[ch] = a_up ? count_model[ch] + 32'd1 : count_model[ch] - 32'd1;
            p = nb_a;
         end else if (near_level(raw, nb_b)) begin
            count_model[ch] = a_up ? count_model[ch] - 32'd1 : count_model[ch] + 32'd1;
            p = nb_b;
         end
      end
      phase_model[ch] = p;
      r.count = count_model[ch];
      r.phase = p;
      return r;
   endfunction

   function automatic void note_failure(input string msg);
      fail_count++;
      if (fail_count <= 10) $display("%s", msg);
   endfunction

   task automatic send_word(input logic cmd, input logic [rsld_pkg::ChanW-1:0] ch,
                            input logic [rsld_pkg::RawW-1:0] raw,
                            input logic [rsld_pkg::CountW-1:0] pos);
      req_bus.valid     <= 1'b1;
      req_bus.command   <= cmd;
      req_bus.channel   <= ch;
      req_bus.raw_value <= raw;
      req_bus.position  <= pos;
      do @(posedge clock); while (req_bus.ready !== 1'b1);
      expected_words.push_back(decode_word(cmd, ch, raw, pos));
      while ($urandom_range(99) < src_idle_pct) begin
         req_bus.valid <= 1'b0;
         @(posedge clock);
      end
   endtask

   task automatic settle_block();
      req_bus.valid <= 1'b0;
      while (expected_words.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic write_levels(input logic [rsld_pkg::RawW-1:0] l0,
                               input logic [rsld_pkg::RawW-1:0] l1,
                               input logic [rsld_pkg::RawW-1:0] l2,
                               input logic [rsld_pkg::RawW-1:0] l3,
                               input logic [rsld_pkg::RawW-1:0] w);
      rsld_pkg::csr_index_type   regs [5];
      logic [rsld_pkg::RawW-1:0] vals [5];
      regs = '{rsld_pkg::REG_LEVEL_ZERO, rsld_pkg::REG_LEVEL_ONE, rsld_pkg::REG_LEVEL_TWO,
               rsld_pkg::REG_LEVEL_THREE, rsld_pkg::REG_WINDOW_WIDTH};
      vals = '{l0, l1, l2, l3, w};
      for (int i = 0; i < 5; i++) begin
         csr_bus.valid <= 1'b1;
         csr_bus.index <= regs[i];
         csr_bus.data  <= vals[i];
         do @(posedge clock); while (csr_bus.ready !== 1'b1);
         case (regs[i])
            rsld_pkg::REG_LEVEL_ZERO:   level_reg[0] = vals[i];
            rsld_pkg::REG_LEVEL_ONE:    level_reg[1] = vals[i];
            rsld_pkg::REG_LEVEL_TWO:    level_reg[2] = vals[i];
            rsld_pkg::REG_LEVEL_THREE:  level_reg[3] = vals[i];
            rsld_pkg::REG_WINDOW_WIDTH: window_reg   = vals[i];
            default: ;
         endcase
      end
      csr_bus.valid <= 1'b0;
   endtask

   task automatic random_levels();
      logic [rsld_pkg::RawW-1:0] lv [rsld_pkg::NumLevels];
      logic [rsld_pkg::RawW-1:0] w;
      for (int k = 0; k < rsld_pkg::NumLevels; k++) begin
         lv[k] = ($urandom_range(3) == 0) ? 16'($urandom) : {10'($urandom_range(1023)), 6'b0};
      end
      case ($urandom_range(3))
         0: w = 16'($urandom);
         1: w = 16'($urandom_range(15));
         default: w = {10'($urandom_range(100)), 6'b0};
      endcase
      write_levels(lv[0], lv[1], lv[2], lv[3], w);
   endtask

   // mostly values around a level, window edges included
   task automatic random_word();
      logic                       cmd;
      logic [rsld_pkg::ChanW-1:0] ch;
      logic [rsld_pkg::RawW-1:0]  raw;
      int                         span;
      int                         v;
      cmd = ($urandom_range(99) < 8) ? rsld_pkg::CmdSet : rsld_pkg::CmdSample;
      ch  = ($urandom_range(99) < 5) ? {rsld_pkg::ChanW{1'b1}} :
            rsld_pkg::ChanW'($urandom_range(rsld_pkg::NumChannels - 1));
      if ($urandom_range(99) < 15) begin
         raw = 16'($urandom);
      end else begin
         span = int'(window_reg) + 1;
         v = int'(level_reg[$urandom_range(rsld_pkg::NumLevels - 1)]) +
             int'($urandom_range(2 * span)) - span;
         if (v < 0) v = 0;
         else if (v > 65535) v = 65535;
         raw = rsld_pkg::RawW'(v);
      end
      send_word(cmd, ch, raw, $urandom);
   endtask

   task automatic test_decode_directed();
      logic [rsld_pkg::RawW-1:0] lv0;
      logic [rsld_pkg::RawW-1:0] lv1;
      logic [rsld_pkg::RawW-1:0] lv2;
      logic [rsld_pkg::RawW-1:0] lv3;
      logic [rsld_pkg::RawW-1:0] w;
      lv0 = level_reg[0];
      lv1 = level_reg[1];
      lv2 = level_reg[2];
      lv3 = level_reg[3];
      w   = window_reg;
      src_idle_pct  = 0;
      snk_stall_pct = 0;
      send_word(rsld_pkg::CmdSet,    2'd0, 16'h0000, 32'h7FFF_FFFF);
      send_word(rsld_pkg::CmdSample, 2'd0, lv3, '0);
      send_word(rsld_pkg::CmdSample, 2'd0, lv0, '0);
      send_word(rsld_pkg::CmdSample, 2'd0, lv3 - w + 16'd1, '0);
      send_word(rsld_pkg::CmdSample, 2'd0, lv2 - w, '0);
      send_word(rsld_pkg::CmdSample, 2'd0, lv2 + w - 16'd1, '0);
      send_word(rsld_pkg::CmdSample, 2'd0, lv1, '0);
      send_word(rsld_pkg::CmdSample, 2'd0, lv2, '0);
      send_word(rsld_pkg::CmdSample, 2'd0, lv1, '0);
      send_word(rsld_pkg::CmdSample, 2'd0, 16'hFFFF, '0);
      send_word(rsld_pkg::CmdSample, 2'd0, lv1, '0);
      send_word(rsld_pkg::CmdSet,    2'd1, lv2, 32'h8000_0000);
      send_word(rsld_pkg::CmdSample, 2'd1, lv1, '0);
      send_word(rsld_pkg::CmdSet,    2'd1, lv2 + 16'd1, '0);
      send_word(rsld_pkg::CmdSet,    2'd2, lv3, '1);
      send_word(rsld_pkg::CmdSet,    2'd2, lv3 + 16'd1, 32'd1);
      send_word(rsld_pkg::CmdSet,    2'd2, lv1, 32'h5555_5555);
      send_word(rsld_pkg::CmdSet,    2'd2, lv1 + 16'd1, 32'hAAAA_AAAA);
      send_word(rsld_pkg::CmdSet,    2'd2, 16'hFFFF, 32'd1);
      send_word(rsld_pkg::CmdSample, 2'd3, lv1, '1);
      send_word(rsld_pkg::CmdSet,    2'd3, 16'h0000, 32'h1234_5678);
      send_word(rsld_pkg::CmdSample, 2'd1, 16'h0000, '0);
      settle_block();
   endtask

   task automatic test_register_extremes();
      logic [rsld_pkg::RawW-1:0] corner [5][5];
      corner = '{
         '{rsld_pkg::LevelZeroReset, rsld_pkg::LevelOneReset, rsld_pkg::LevelTwoReset,
           rsld_pkg::LevelThreeReset, 16'h0000},
         '{rsld_pkg::LevelZeroReset, rsld_pkg::LevelOneReset, rsld_pkg::LevelTwoReset,
           rsld_pkg::LevelThreeReset, 16'hFFFF},
         '{16'h0000, 16'h0000, 16'h0000, 16'h0000, 16'h0001},
         '{16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF},
         '{16'h0000, 16'hFFFF, 16'h0000, 16'hFFFF, 16'h8000}
      };
      src_idle_pct  = 19;
      snk_stall_pct = 19;
      for (int s = 0; s < 5; s++) begin
         settle_block();
         write_levels(corner[s][0], corner[s][1], corner[s][2], corner[s][3], corner[s][4]);
         repeat (20) random_word();
      end
      settle_block();
   endtask

   task automatic test_random_traffic();
      int src_mix [4];
      int snk_mix [4];
      src_mix = '{0, 64, 0, 19};
      snk_mix = '{0, 0, 64, 19};
      for (int p = 0; p < 4; p++) begin
         src_idle_pct  = src_mix[p];
         snk_stall_pct = snk_mix[p];
         for (int n = 0; n < 430; n++) begin
            if (n % 143 == 0) begin
               settle_block();
               random_levels();
            end else if ($urandom_range(199) == 0) begin
               settle_block();
            end
            random_word();
         end
      end
      settle_block();
   endtask

   initial begin : rsp_checker
      rsld_pkg::result_type want;
      rsp_bus.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) begin
            if (expected_words.size() == 0) begin
               note_failure($sformatf("unexpected word: ch %0d count %h phase %0d",
                                      rsp_bus.out_channel, rsp_bus.count, rsp_bus.phase));
            end else begin
               want = expected_words.pop_front();
               if (want.out_channel !== rsp_bus.out_channel || want.count !== rsp_bus.count ||
                   want.phase !== rsp_bus.phase) begin
                  note_failure($sformatf({"word mismatch: expected ch %0d count %h phase %0d,",
                                          " got ch %0d count %h phase %0d"},
                                         want.out_channel, want.count, want.phase,
                                         rsp_bus.out_channel, rsp_bus.count, rsp_bus.phase));
               end
            end
         end
         rsp_bus.ready <= ($urandom_range(99) >= snk_stall_pct);
      end
   end

   initial begin : watchdog
      int quiet;
      quiet = 0;
      while (quiet < QuietLimit) begin
         @(posedge clock);
         if ((req_bus.valid === 1'b1 && req_bus.ready === 1'b1) ||
             (rsp_bus.valid === 1'b1 && rsp_bus.ready === 1'b1) ||
             (csr_bus.valid === 1'b1 && csr_bus.ready === 1'b1)) quiet = 0;
         else quiet++;
      end
      $display("rotation_sensor_level_decoder verification failed");
      $finish;
   end

   initial begin
      reset             = 1'b1;
      req_bus.valid     = 1'b0;
      req_bus.command   = rsld_pkg::CmdSample;
      req_bus.channel   = '0;
      req_bus.raw_value = '0;
      req_bus.position  = '0;
      csr_bus.valid     = 1'b0;
      csr_bus.index     = rsld_pkg::REG_LEVEL_ZERO;
      csr_bus.data      = '0;
      src_idle_pct      = 0;
      snk_stall_pct     = 0;
      fail_count        = 0;
      level_reg         = '{rsld_pkg::LevelZeroReset, rsld_pkg::LevelOneReset,
                            rsld_pkg::LevelTwoReset, rsld_pkg::LevelThreeReset};
      window_reg        = rsld_pkg::WindowReset;
      for (int c = 0; c < rsld_pkg::NumChannels; c++) begin
         phase_model[c] = '0;
         count_model[c] = '0;
      end
      repeat (7) @(posedge clock);
      reset <= 1'b0;
      test_decode_directed();
      test_register_extremes();
      test_random_traffic();
      if (fail_count == 0 && expected_words.size() == 0) begin
         $display("rotation_sensor_level_decoder verification clean");
      end else begin
         $display("rotation_sensor_level_decoder verification failed");
      end
      $finish;
   end

endmodule

// ----- files.f -----
design/rsld_pkg.sv
design/rsld_if.sv
design/rsld_front.sv
design/rsld_queue.sv
design/rsld_back.sv
design/rotation_sensor_level_decoder.sv
tb/sv/tb.sv
